@@ rtl/wshp_pkg.sv @@
package wshp_pkg;

  // default sizes
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned PREVIEW_MAX_DEF   = 16;
  // most results one request may cause
  localparam int unsigned RESULT_LIMIT      = 16;

  // operation codes
  localparam logic [3:0] MODE_ADD     = 4'd0;
  localparam logic [3:0] MODE_ENABLE  = 4'd1;
  localparam logic [3:0] MODE_DISABLE = 4'd2;
  localparam logic [3:0] MODE_REMOVE  = 4'd3;
  localparam logic [3:0] MODE_SETW    = 4'd4;
  localparam logic [3:0] MODE_INC     = 4'd5;
  localparam logic [3:0] MODE_DEC     = 4'd6;
  localparam logic [3:0] MODE_PICK    = 4'd7;
  localparam logic [3:0] MODE_PREVIEW = 4'd8;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // one table entry as stored in memory
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  weight;
    logic [15:0] count;
    logic        enabled;
    logic [31:0] stamp;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rescan;
    logic rd;
    logic chk;
    logic div_start;
    logic best_upd;
    logic idx_inc;
    logic emit_pick;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pick;
    logic is_preview;
    logic elig;
    logic idx_last;
    logic div_done;
    logic out_last;
  } sts_t;

endpackage

@@ rtl/wshp_div.sv @@
module wshp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic        busy,
  output logic        done,
  output logic [15:0] quotient
);

  logic [7:0]  rem;
  logic [7:0]  dvs;
  logic [15:0] quo;
  logic [3:0]  cnt;
  logic [8:0]  rem_sh;
  logic        take;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem, quo[15]};
  assign take   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= '0;
      end else if (busy) begin
        if (take) begin
          rem <= 8'(rem_sh - {1'b0, dvs});
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= rem_sh[7:0];
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/wshp_datapath.sv @@
module wshp_datapath #(
  parameter int unsigned TABLE_ENTRIES = wshp_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned PREVIEW_MAX   = wshp_pkg::PREVIEW_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  wshp_pkg::cmd_t  cmd,
  output wshp_pkg::sts_t  sts,
  input  logic [3:0]      mode,
  input  logic [31:0]     host_addr,
  input  logic [15:0]     host_port,
  input  logic [7:0]      weight,
  input  logic [4:0]      pick_count,
  output logic [1:0]      status,
  output logic [31:0]     picked_addr,
  output logic [15:0]     picked_port,
  output logic            last
);

  localparam int unsigned IW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned PL  = (PREVIEW_MAX < wshp_pkg::RESULT_LIMIT) ?
                                PREVIEW_MAX : wshp_pkg::RESULT_LIMIT;
  localparam int unsigned PNW = $clog2(PL + 1);
  localparam int unsigned PLW = (PL > 1) ? $clog2(PL) : 1;

  // captured request
  logic [3:0]  mode_r;
  logic [31:0] addr_r;
  logic [15:0] port_r;
  logic [7:0]  weight_r;
  logic [PNW-1:0] n_r;

  // table storage
  wshp_pkg::entry_t mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vbits;
  logic [31:0] next_stamp;

  // scan state
  logic [IW-1:0]    idx;
  logic [IW-1:0]    rd_idx;
  wshp_pkg::entry_t rdata;
  logic             valid_q;
  logic             found;
  logic [IW-1:0]    found_idx;
  wshp_pkg::entry_t found_ent;
  logic             free_found;
  logic [IW-1:0]    free_idx;

  // best candidate of the current pick
  logic          best_found;
  logic [IW-1:0] best_idx;
  logic [15:0]   best_q;
  logic [31:0]   best_age;
  logic [31:0]   best_addr;
  logic [15:0]   best_port;

  // picks made so far in a preview
  logic [IW-1:0]  pk_list [PL];
  logic [PL-1:0]  pk_ok;
  logic [PNW-1:0] pk_n;

  logic [4:0]     n_sat;
  logic [PNW-1:0] hit_cnt;
  logic [16:0]    cnt_sum;
  logic [15:0]    cnt_eff;
  logic [31:0]    age;
  logic           key_hit;
  logic           better;
  logic           div_busy;
  logic           div_done;
  logic [15:0]    quo;

  // exec results
  logic             wr_en;
  logic [IW-1:0]    wr_idx;
  wshp_pkg::entry_t wr_data;
  logic [1:0]       ex_st;
  logic             set_v;
  logic             clr_v;

  // preview count: zero acts as one, large values saturate
  always_comb begin
    if (pick_count == 5'd0) begin
      n_sat = 5'd1;
    end else if ({27'd0, pick_count} > PL) begin
      n_sat = 5'(PL);
    end else begin
      n_sat = pick_count;
    end
  end

  // earlier preview picks that hit the entry being read
  always_comb begin
    hit_cnt = '0;
    for (int k = 0; k < PL; k++) begin
      if ((PNW'(k) < pk_n) && pk_ok[k] && (pk_list[k] == rd_idx)) begin
        hit_cnt = hit_cnt + PNW'(1);
      end
    end
  end

  assign cnt_sum = {1'b0, rdata.count} + 17'(hit_cnt);
  assign cnt_eff = cnt_sum[16] ? wshp_pkg::COUNT_MAX : cnt_sum[15:0];
  assign age     = next_stamp - rdata.stamp;
  assign key_hit = valid_q && (rdata.addr == addr_r) && (rdata.port == port_r);
  assign better  = !best_found || (quo < best_q) || ((quo == best_q) && (age < best_age));

  wshp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cnt_eff),
    .divisor  (rdata.weight),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  // status to controller
  always_comb begin
    sts.is_pick    = (mode_r == wshp_pkg::MODE_PICK) || (mode_r == wshp_pkg::MODE_PREVIEW);
    sts.is_preview = (mode_r == wshp_pkg::MODE_PREVIEW);
    sts.elig       = valid_q && rdata.enabled && (rdata.weight != 8'd0);
    sts.idx_last   = (idx == IW'(TABLE_ENTRIES - 1));
    sts.div_done   = div_done;
    sts.out_last   = last;
  end

  // table operation for non-pick modes
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = found_idx;
    wr_data = found_ent;
    ex_st   = wshp_pkg::ST_FAIL;
    set_v   = 1'b0;
    clr_v   = 1'b0;
    case (mode_r)
      wshp_pkg::MODE_ADD: begin
        if (found) begin
          wr_en           = 1'b1;
          wr_data.weight  = weight_r;
          wr_data.enabled = 1'b1;
          ex_st           = wshp_pkg::ST_OK;
        end else if (free_found) begin
          wr_en           = 1'b1;
          wr_idx          = free_idx;
          wr_data.addr    = addr_r;
          wr_data.port    = port_r;
          wr_data.weight  = weight_r;
          wr_data.count   = '0;
          wr_data.enabled = 1'b1;
          wr_data.stamp   = next_stamp;
          set_v           = 1'b1;
          ex_st           = wshp_pkg::ST_OK;
        end else begin
          ex_st = wshp_pkg::ST_FULL;
        end
      end
      wshp_pkg::MODE_ENABLE, wshp_pkg::MODE_DISABLE: begin
        if (found) begin
          wr_en           = 1'b1;
          wr_data.enabled = (mode_r == wshp_pkg::MODE_ENABLE);
          ex_st           = wshp_pkg::ST_OK;
        end
      end
      wshp_pkg::MODE_REMOVE: begin
        clr_v = found;
        ex_st = wshp_pkg::ST_OK;
      end
      wshp_pkg::MODE_SETW: begin
        if (found) begin
          wr_en          = 1'b1;
          wr_data.weight = weight_r;
          ex_st          = wshp_pkg::ST_OK;
        end
      end
      wshp_pkg::MODE_INC: begin
        if (found) begin
          wr_en = 1'b1;
          if (found_ent.count != wshp_pkg::COUNT_MAX) begin
            wr_data.count = found_ent.count + 16'd1;
          end
          ex_st = wshp_pkg::ST_OK;
        end
      end
      wshp_pkg::MODE_DEC: begin
        if (found && (found_ent.count != 16'd0)) begin
          wr_en         = 1'b1;
          wr_data.count = found_ent.count - 16'd1;
          ex_st         = wshp_pkg::ST_OK;
        end
      end
      default: begin
        ex_st = wshp_pkg::ST_FAIL;
      end
    endcase
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.rd) begin
      rdata <= mem[idx];
    end
  end

  // valid bits and stamp counter
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits      <= '0;
      next_stamp <= '0;
    end else if (cmd.exec) begin
      if (set_v) begin
        vbits[free_idx] <= 1'b1;
        next_stamp      <= next_stamp + 32'd1;
      end
      if (clr_v) begin
        vbits[found_idx] <= 1'b0;
      end
    end
  end

  // scan, pick and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
      pk_n       <= '0;
      idx        <= '0;
    end else begin
      if (cmd.load) begin
        mode_r     <= mode;
        addr_r     <= host_addr;
        port_r     <= host_port;
        weight_r   <= weight;
        n_r        <= PNW'(n_sat);
        idx        <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
        best_found <= 1'b0;
        pk_n       <= '0;
      end
      if (cmd.rescan) begin
        idx        <= '0;
        best_found <= 1'b0;
      end
      if (cmd.rd) begin
        valid_q <= vbits[idx];
        rd_idx  <= idx;
      end
      if (cmd.chk) begin
        if (key_hit && !found) begin
          found     <= 1'b1;
          found_idx <= rd_idx;
          found_ent <= rdata;
        end
        if (!valid_q && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
      if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (cmd.best_upd && better) begin
        best_found <= 1'b1;
        best_idx   <= rd_idx;
        best_q     <= quo;
        best_age   <= age;
        best_addr  <= rdata.addr;
        best_port  <= rdata.port;
      end
      if (cmd.emit_pick) begin
        status      <= best_found ? wshp_pkg::ST_OK : wshp_pkg::ST_FAIL;
        picked_addr <= best_found ? best_addr : 32'd0;
        picked_port <= best_found ? best_port : 16'd0;
        last        <= (mode_r == wshp_pkg::MODE_PICK) || (PNW'(pk_n + PNW'(1)) == n_r);
        if (pk_n < PNW'(PL)) begin
          pk_list[pk_n[PLW-1:0]] <= best_idx;
          pk_ok[pk_n[PLW-1:0]]   <= best_found;
          pk_n                   <= pk_n + PNW'(1);
        end
      end
      if (cmd.exec) begin
        status      <= ex_st;
        picked_addr <= '0;
        picked_port <= '0;
        last        <= 1'b1;
      end
    end
  end

  // divider is only started when free
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  // preview never records more picks than it may make
  assert property (@(posedge clk) disable iff (rst) pk_n <= PNW'(PL))
    else $error("pick list overrun");

  // an entry found by key is still valid when the operation runs
  assert property (@(posedge clk) disable iff (rst) (cmd.exec && found) |-> vbits[found_idx])
    else $error("found entry not valid");

endmodule

@@ rtl/wshp_ctrl.sv @@
module wshp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output wshp_pkg::cmd_t cmd,
  input  wshp_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_DIV,
    S_NEXT,
    S_END,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.is_pick) begin
          if (sts.elig) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            state_next = S_NEXT;
          end
        end else begin
          cmd.chk    = 1'b1;
          state_next = S_NEXT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.best_upd = 1'b1;
          state_next   = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts.idx_last) begin
          state_next = S_END;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_RD;
        end
      end
      S_END: begin
        if (sts.is_pick) begin
          cmd.emit_pick = 1'b1;
        end else begin
          cmd.exec = 1'b1;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (sts.is_preview && !sts.out_last) begin
            cmd.rescan = 1'b1;
            state_next = S_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // a request is never taken while a result waits
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready with result pending");

  // every result follows a table operation or a pick
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.exec || cmd.emit_pick))
    else $error("result without operation");

  // the divider finishes only while waiting on it
  assert property (@(posedge clk) disable iff (rst) sts.div_done |-> state == S_DIV)
    else $error("divider done outside divide state");

endmodule

@@ rtl/weighted_host_slot_picker_top.sv @@
// channel   signals                                               direction
// request   in_valid, in_ready, mode, host_addr, host_port,       in
//           weight, pick_count
// result    out_valid, out_ready, status, picked_addr,            out
//           picked_port, last
//
// one request at a time; each table scan reads the entries from memory one after another
// non-pick operation: read, check and next for each entry, then the operation, then the result handshake
// each pick: read, check and next for each entry, plus a divide for each eligible entry (16-step divider)
// preview repeats the pick scan once per result, up to 16 results
// reset clears all valid bits at once; no clearing pass
// a stalled result holds the block in place until it is taken
module weighted_host_slot_picker_top #(
  parameter int unsigned TABLE_ENTRIES = wshp_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned PREVIEW_MAX   = wshp_pkg::PREVIEW_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  mode,
  input  logic [31:0] host_addr,
  input  logic [15:0] host_port,
  input  logic [7:0]  weight,
  input  logic [4:0]  pick_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] picked_addr,
  output logic [15:0] picked_port,
  output logic        last
);

  wshp_pkg::cmd_t cmd;
  wshp_pkg::sts_t sts;

  wshp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  wshp_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PREVIEW_MAX   (PREVIEW_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (mode),
    .host_addr   (host_addr),
    .host_port   (host_port),
    .weight      (weight),
    .pick_count  (pick_count),
    .status      (status),
    .picked_addr (picked_addr),
    .picked_port (picked_port),
    .last        (last)
  );

endmodule
